/* design/luhn_pkg.sv */
// Shared constants, types and helper functions for the Luhn card number check.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package luhn_pkg;

   localparam int BIN_WIDTH          = 63;
   localparam int DD_STEPS           = 4;
   localparam int DD_STAGES          = (BIN_WIDTH + DD_STEPS - 1) / DD_STEPS;
   localparam int BIN_PAD_WIDTH      = DD_STAGES * DD_STEPS;
   localparam int DEC_DIGITS         = 19;
   localparam int BCD_WIDTH          = DEC_DIGITS * 4;
   localparam int SCORE_STAGES       = 4;
   localparam int LATENCY            = DD_STAGES + SCORE_STAGES;
   localparam int DEFAULT_MAX_DIGITS = 19;
   localparam int SUM_WIDTH          = 8;
   localparam int COUNT_WIDTH        = 5;
   localparam int LEAD_WIDTH         = 7;
   localparam int BRAND_WIDTH        = 2;
   localparam int GROUP_SIZE         = 5;

   typedef logic [3:0]             digit_type;
   typedef logic [SUM_WIDTH-1:0]   sum_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [LEAD_WIDTH-1:0]  lead_type;
   typedef logic [BRAND_WIDTH-1:0] brand_type;

   localparam brand_type BRAND_NONE  = 2'd0;
   localparam brand_type BRAND_PFX34 = 2'd1;
   localparam brand_type BRAND_PFX5X = 2'd2;
   localparam brand_type BRAND_PFX4  = 2'd3;

   function automatic digit_type fold_double(input digit_type d);
      logic [4:0] twice;
      digit_type  r;
      twice = {d, 1'b0};
      if (d > 4'd4) begin
         r = 4'(twice - 5'd9);
      end else begin
         r = twice[3:0];
      end
      return r;
   endfunction

   function automatic digit_type rem_ten(input sum_type s);
      sum_type r;
      r = s;
      if (r >= 8'd160) begin
         r = r - 8'd160;
      end
      if (r >= 8'd80) begin
         r = r - 8'd80;
      end
      if (r >= 8'd40) begin
         r = r - 8'd40;
      end
      if (r >= 8'd20) begin
         r = r - 8'd20;
      end
      if (r >= 8'd10) begin
         r = r - 8'd10;
      end
      return r[3:0];
   endfunction

   function automatic lead_type times_ten_plus(input digit_type hi, input digit_type lo);
      lead_type r;
      r = LEAD_WIDTH'({hi, 3'b000}) + LEAD_WIDTH'({hi, 1'b0}) + LEAD_WIDTH'(lo);
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/luhn_card_number_check.sv */
// Top level of the Luhn card number check: the BCD conversion pipeline
// followed by the scoring stages. Depends on luhn_pkg, luhn_dabble, luhn_score.
//
// Usage:
// A transaction is accepted at a rising edge where start is high and busy is
// low. busy is always low: the pipeline takes a new card number every cycle.
// The card number is converted to decimal in 16 shift-and-add-three stages of
// four bits each, then weighted, summed and checked in four more stages.
// rsp_strobe is high for exactly one cycle per transaction, once it has left
// the conversion and scoring stages, with rsp_luhn_ok, rsp_digit_count,
// rsp_leading_digits and rsp_card_brand valid in that cycle. Results leave in
// the order the transactions were accepted, one per cycle at most.
// Each result passes the conversion depth (16 stages), then the four scoring
// stages; throughput is one transaction per cycle.
// The receiver cannot stall the block, so results are never held back.
// Reset clears every valid bit in the pipeline; transactions in flight are
// dropped and no strobe appears until new work enters.
`default_nettype none

module luhn_card_number_check #(
   parameter int MAX_DIGITS = luhn_pkg::DEFAULT_MAX_DIGITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [luhn_pkg::BIN_WIDTH-1:0] req_card_number,
   output logic                                rsp_strobe,
   output logic                                rsp_luhn_ok,
   output luhn_pkg::count_type                 rsp_digit_count,
   output luhn_pkg::lead_type                  rsp_leading_digits,
   output luhn_pkg::brand_type                 rsp_card_brand
);

   logic                               dd_valid [luhn_pkg::DD_STAGES+1];
   logic [luhn_pkg::BIN_PAD_WIDTH-1:0] dd_bin   [luhn_pkg::DD_STAGES+1];
   logic [luhn_pkg::BCD_WIDTH-1:0]     dd_bcd   [luhn_pkg::DD_STAGES+1];

   assign busy        = 1'b0;
   assign dd_valid[0] = start & ~busy;
   assign dd_bin[0]   = luhn_pkg::BIN_PAD_WIDTH'(req_card_number);
   assign dd_bcd[0]   = '0;

   for (genvar k = 0; k < luhn_pkg::DD_STAGES; k++) begin : g_dabble
      luhn_dabble u_dabble (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dd_valid[k]),
         .in_bin    (dd_bin[k]),
         .in_bcd    (dd_bcd[k]),
         .out_valid (dd_valid[k+1]),
         .out_bin   (dd_bin[k+1]),
         .out_bcd   (dd_bcd[k+1])
      );
   end

   luhn_score #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_score (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (dd_valid[luhn_pkg::DD_STAGES]),
      .in_bcd             (dd_bcd[luhn_pkg::DD_STAGES]),
      .out_valid          (rsp_strobe),
      .out_luhn_ok        (rsp_luhn_ok),
      .out_digit_count    (rsp_digit_count),
      .out_leading_digits (rsp_leading_digits),
      .out_card_brand     (rsp_card_brand)
   );

endmodule

`default_nettype wire

/* design/luhn_dabble.sv */
// One pipeline stage of the binary to BCD conversion (shift and add three).
// Each stage handles a fixed number of input bits; depends on luhn_pkg.
`default_nettype none

module luhn_dabble (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   input  wire logic [luhn_pkg::BIN_PAD_WIDTH-1:0] in_bin,
   input  wire logic [luhn_pkg::BCD_WIDTH-1:0]     in_bcd,
   output logic                                    out_valid,
   output logic      [luhn_pkg::BIN_PAD_WIDTH-1:0] out_bin,
   output logic      [luhn_pkg::BCD_WIDTH-1:0]     out_bcd
);

   logic                               valid_ff;
   logic [luhn_pkg::BIN_PAD_WIDTH-1:0] bin_ff;
   logic [luhn_pkg::BIN_PAD_WIDTH-1:0] bin_in;
   logic [luhn_pkg::BCD_WIDTH-1:0]     bcd_ff;
   logic [luhn_pkg::BCD_WIDTH-1:0]     bcd_in;

   always_comb begin
      bin_in = in_bin;
      bcd_in = in_bcd;
      for (int s = 0; s < luhn_pkg::DD_STEPS; s++) begin
         for (int j = 0; j < luhn_pkg::DEC_DIGITS; j++) begin
            if (bcd_in[4*j +: 4] >= 4'd5) begin
               bcd_in[4*j +: 4] = bcd_in[4*j +: 4] + 4'd3;
            end
         end
         bcd_in = {bcd_in[luhn_pkg::BCD_WIDTH-2:0], bin_in[luhn_pkg::BIN_PAD_WIDTH-1]};
         bin_in = {bin_in[luhn_pkg::BIN_PAD_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign out_valid = valid_ff;
   assign out_bin   = bin_ff;
   assign out_bcd   = bcd_ff;

endmodule

`default_nettype wire

/* design/luhn_score.sv */
// Four-stage back end: digit weighting and count, partial sums and leading
// digits, total sum, then the mod ten check and brand code. Depends on luhn_pkg.
`default_nettype none

module luhn_score #(
   parameter int MAX_DIGITS = luhn_pkg::DEFAULT_MAX_DIGITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [luhn_pkg::BCD_WIDTH-1:0] in_bcd,
   output logic                                out_valid,
   output logic                                out_luhn_ok,
   output luhn_pkg::count_type                 out_digit_count,
   output luhn_pkg::lead_type                  out_leading_digits,
   output luhn_pkg::brand_type                 out_card_brand
);

   localparam int GROUPS = (MAX_DIGITS + luhn_pkg::GROUP_SIZE - 1) / luhn_pkg::GROUP_SIZE;

   logic                 valid_a_ff;
   luhn_pkg::digit_type  dig_a_ff [MAX_DIGITS];
   luhn_pkg::digit_type  wgt_a_in [MAX_DIGITS];
   luhn_pkg::digit_type  wgt_a_ff [MAX_DIGITS];
   luhn_pkg::count_type  cnt_a_in;
   luhn_pkg::count_type  cnt_a_ff;

   logic                 valid_b_ff;
   luhn_pkg::sum_type    grp_b_in [GROUPS];
   luhn_pkg::sum_type    grp_b_ff [GROUPS];
   luhn_pkg::lead_type   lead_b_in;
   luhn_pkg::lead_type   lead_b_ff;
   luhn_pkg::count_type  cnt_b_ff;

   logic                 valid_c_ff;
   luhn_pkg::sum_type    sum_c_in;
   luhn_pkg::sum_type    sum_c_ff;
   luhn_pkg::lead_type   lead_c_ff;
   luhn_pkg::count_type  cnt_c_ff;

   logic                 valid_d_ff;
   logic                 ok_d_in;
   logic                 ok_d_ff;
   luhn_pkg::brand_type  brand_d_in;
   luhn_pkg::brand_type  brand_d_ff;
   luhn_pkg::lead_type   lead_d_ff;
   luhn_pkg::count_type  cnt_d_ff;

   // Digits above MAX_DIGITS are never weighted; they only saturate the count.
   always_comb begin
      cnt_a_in = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if ((i % 2) == 1) begin
            wgt_a_in[i] = luhn_pkg::fold_double(in_bcd[4*i +: 4]);
         end else begin
            wgt_a_in[i] = in_bcd[4*i +: 4];
         end
      end
      for (int i = 0; i < luhn_pkg::DEC_DIGITS; i++) begin
         if (in_bcd[4*i +: 4] != 4'd0) begin
            if (i < MAX_DIGITS) begin
               cnt_a_in = luhn_pkg::COUNT_WIDTH'(i + 1);
            end else begin
               cnt_a_in = luhn_pkg::COUNT_WIDTH'(MAX_DIGITS);
            end
         end
      end
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_b_in[g] = '0;
         for (int k = 0; k < luhn_pkg::GROUP_SIZE; k++) begin
            if (g * luhn_pkg::GROUP_SIZE + k < MAX_DIGITS) begin
               grp_b_in[g] = grp_b_in[g] +
                  luhn_pkg::SUM_WIDTH'(wgt_a_ff[g * luhn_pkg::GROUP_SIZE + k]);
            end
         end
      end
      lead_b_in = '0;
      if (cnt_a_ff == luhn_pkg::COUNT_WIDTH'(1)) begin
         lead_b_in = luhn_pkg::LEAD_WIDTH'(dig_a_ff[0]);
      end
      for (int i = 1; i < MAX_DIGITS; i++) begin
         if (cnt_a_ff == luhn_pkg::COUNT_WIDTH'(i + 1)) begin
            lead_b_in = luhn_pkg::times_ten_plus(dig_a_ff[i], dig_a_ff[i-1]);
         end
      end
   end

   always_comb begin
      sum_c_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         sum_c_in = sum_c_in + grp_b_ff[g];
      end
   end

   always_comb begin
      ok_d_in    = (luhn_pkg::rem_ten(sum_c_ff) == 4'd0);
      brand_d_in = luhn_pkg::BRAND_NONE;
      if (ok_d_in) begin
         if (cnt_c_ff == luhn_pkg::COUNT_WIDTH'(15) &&
             (lead_c_ff == 7'd34 || lead_c_ff == 7'd37)) begin
            brand_d_in = luhn_pkg::BRAND_PFX34;
         end else if (cnt_c_ff == luhn_pkg::COUNT_WIDTH'(16) &&
                      lead_c_ff >= 7'd51 && lead_c_ff <= 7'd55) begin
            brand_d_in = luhn_pkg::BRAND_PFX5X;
         end else if ((cnt_c_ff == luhn_pkg::COUNT_WIDTH'(13) ||
                       cnt_c_ff == luhn_pkg::COUNT_WIDTH'(16)) &&
                      lead_c_ff >= 7'd40 && lead_c_ff <= 7'd49) begin
            brand_d_in = luhn_pkg::BRAND_PFX4;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
         valid_d_ff <= valid_c_ff;
      end
      for (int i = 0; i < MAX_DIGITS; i++) begin
         dig_a_ff[i] <= in_bcd[4*i +: 4];
         wgt_a_ff[i] <= wgt_a_in[i];
      end
      cnt_a_ff <= cnt_a_in;
      for (int g = 0; g < GROUPS; g++) begin
         grp_b_ff[g] <= grp_b_in[g];
      end
      lead_b_ff  <= lead_b_in;
      cnt_b_ff   <= cnt_a_ff;
      sum_c_ff   <= sum_c_in;
      lead_c_ff  <= lead_b_ff;
      cnt_c_ff   <= cnt_b_ff;
      ok_d_ff    <= ok_d_in;
      brand_d_ff <= brand_d_in;
      lead_d_ff  <= lead_c_ff;
      cnt_d_ff   <= cnt_c_ff;
   end

   assign out_valid          = valid_d_ff;
   assign out_luhn_ok        = ok_d_ff;
   assign out_digit_count    = cnt_d_ff;
   assign out_leading_digits = lead_d_ff;
   assign out_card_brand     = brand_d_ff;

endmodule

`default_nettype wire

/* design/luhn_chk.sv */
// Port-level checker for the Luhn card number check, bound to the top level.
// Depends on luhn_pkg and luhn_card_number_check.
`default_nettype none

module luhn_chk #(
   parameter int MAX_DIGITS = luhn_pkg::DEFAULT_MAX_DIGITS
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic [luhn_pkg::BIN_WIDTH-1:0] req_card_number,
   input wire logic                           rsp_strobe,
   input wire logic                           rsp_luhn_ok,
   input wire luhn_pkg::count_type            rsp_digit_count,
   input wire luhn_pkg::lead_type             rsp_leading_digits,
   input wire luhn_pkg::brand_type            rsp_card_brand
);

   // Every accepted transaction produces its result after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(luhn_pkg::LATENCY) rsp_strobe)
      else $error("accepted transaction did not produce a result in time");

   // A card number of zero must report no digits and a passing check.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_card_number == '0) |-> ##(luhn_pkg::LATENCY)
      (rsp_digit_count == '0 && rsp_leading_digits == '0 && rsp_luhn_ok))
      else $error("zero card number gave a wrong result");

   // A brand is only reported for a number that passes the check.
   a_brand_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_card_brand != luhn_pkg::BRAND_NONE) |-> rsp_luhn_ok)
      else $error("brand reported for a failed check");

   a_brand_pfx34: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_card_brand == luhn_pkg::BRAND_PFX34) |->
      (rsp_digit_count == luhn_pkg::COUNT_WIDTH'(15) &&
       (rsp_leading_digits == 7'd34 || rsp_leading_digits == 7'd37)))
      else $error("brand code does not match length and prefix");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_digit_count <= luhn_pkg::COUNT_WIDTH'(MAX_DIGITS)))
      else $error("digit count exceeds the examined digits");

endmodule

bind luhn_card_number_check luhn_chk #(
   .MAX_DIGITS (MAX_DIGITS)
) u_luhn_chk (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_card_number    (req_card_number),
   .rsp_strobe         (rsp_strobe),
   .rsp_luhn_ok        (rsp_luhn_ok),
   .rsp_digit_count    (rsp_digit_count),
   .rsp_leading_digits (rsp_leading_digits),
   .rsp_card_brand     (rsp_card_brand)
);

`default_nettype wire
